[rtl/twrtc_pkg.sv]
package twrtc_pkg;

    // default number of bytes in a clock burst
    localparam int unsigned BurstBytesDefault = 7;
    // entries of the request queue between front and back
    localparam int unsigned QueueDepthDefault = 2;

    // command byte control bits and the clock burst address
    localparam logic [7:0] CMD_RD = 8'h81;
    localparam logic [7:0] CMD_WR = 8'h80;
    localparam logic [5:0] CLOCK_BURST_ADDR = 6'h1F;

    // operation codes
    localparam logic [1:0] OP_SINGLE_RD = 2'd0;
    localparam logic [1:0] OP_SINGLE_WR = 2'd1;
    localparam logic [1:0] OP_BURST_RD  = 2'd2;
    localparam logic [1:0] OP_BURST_WR  = 2'd3;

    // configuration register indexes
    localparam logic CFG_HALF_BIT = 1'b0;
    localparam logic CFG_SETUP    = 1'b1;

    // one classified tick request
    typedef struct packed {
        logic        start_req;
        logic [1:0]  func;
        logic [7:0]  cmd_byte;
        logic [55:0] write_bytes;
        logic        io_in;
    } t_req;

    // pin levels and status for one tick
    typedef struct packed {
        logic [55:0] read_bytes;
        logic        done_res;
        logic        busy_res;
        logic        io_drive;
        logic        io_out;
        logic        serial_clock;
        logic        chip_enable;
    } t_res;

    // index of the final byte of a transaction (command byte is index 0)
    function automatic logic [3:0] last_byte(input logic [1:0] op, input logic [3:0] burst);
        logic [3:0] res;
        begin
            unique case (op)
                OP_SINGLE_RD: res = 4'd1;
                OP_SINGLE_WR: res = 4'd1;
                OP_BURST_RD:  res = burst;
                OP_BURST_WR:  res = burst + 4'd1;
                default:      res = 4'd1;
            endcase
            return res;
        end
    endfunction

endpackage

[rtl/three_wire_rtc_serial_master.sv]
// channel   dir  handshake                        payload
// s_axis    in   s_axis_tvalid / s_axis_tready    tdata: start_req, reg_addr, write_bytes,
//                                                 io_in; tuser: func
// m_axis    out  m_axis_tvalid / m_axis_tready    tdata: chip_enable, serial_clock, io_out,
//                                                 io_drive, busy_res, done_res, read_bytes
// cfg       in   i_cfg_we                         i_cfg_idx, i_cfg_data
//
// one tick request per cycle unless m_axis stalls; the engine does one tick per request
// a request passes the front register, request queue and output register in turn
// reset is synchronous, active low; it clears the engine and sets the timing registers
// a stall on m_axis holds the output register and the engine; the queue and then the
// front register absorb requests until both are full, then s_axis_tready falls
module three_wire_rtc_serial_master #(
    parameter int unsigned BURST_BYTES = twrtc_pkg::BurstBytesDefault,
    parameter int unsigned QUEUE_DEPTH = twrtc_pkg::QueueDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] start_req, [6:1] reg_addr, [62:7] write_bytes, [63] io_in
    input  logic [63:0] s_axis_tdata,
    // [1:0] func
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] chip_enable, [1] serial_clock, [2] io_out, [3] io_drive, [4] busy_res,
    // [5] done_res, [61:6] read_bytes, [63:62] zero
    output logic [63:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);

    logic            front_valid;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;
    twrtc_pkg::t_req front_req;
    twrtc_pkg::t_req q_req;
    twrtc_pkg::t_res res;

    // accept and classify requests
    twrtc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_start_req   (s_axis_tdata[0]),
        .i_func        (s_axis_tuser),
        .i_reg_addr    (s_axis_tdata[6:1]),
        .i_write_bytes (s_axis_tdata[62:7]),
        .i_io_in       (s_axis_tdata[63]),
        .o_valid       (front_valid),
        .i_ready       (!q_full),
        .o_req         (front_req)
    );

    // request queue
    twrtc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_req),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_req)
    );

    // serial engine
    twrtc_back #(
        .BURST_BYTES (BURST_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (q_valid),
        .o_pop      (q_pop),
        .i_req      (q_req),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_res      (res)
    );

    assign m_axis_tdata = {2'b00, res};

endmodule

[rtl/twrtc_front.sv]
module twrtc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_start_req,
    input  logic [1:0]        i_func,
    input  logic [5:0]        i_reg_addr,
    input  logic [55:0]       i_write_bytes,
    input  logic              i_io_in,
    output logic              o_valid,
    input  logic              i_ready,
    output twrtc_pkg::t_req   o_req
);

    logic            r_valid;
    twrtc_pkg::t_req r_req;
    twrtc_pkg::t_req n_req;
    logic [5:0]      addr;

    // command byte from operation and address
    always_comb begin
        addr = i_func[1] ? twrtc_pkg::CLOCK_BURST_ADDR : i_reg_addr;
        n_req.start_req   = i_start_req;
        n_req.func        = i_func;
        n_req.cmd_byte    = {1'b0, addr, 1'b0}
                          | (i_func[0] ? twrtc_pkg::CMD_WR : twrtc_pkg::CMD_RD);
        n_req.write_bytes = i_write_bytes;
        n_req.io_in       = i_io_in;
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    // holding stage in front of the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_req <= n_req;
        end
    end

endmodule

[rtl/twrtc_queue.sv]
module twrtc_queue #(
    parameter int unsigned DEPTH = twrtc_pkg::QueueDepthDefault
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  twrtc_pkg::t_req i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output twrtc_pkg::t_req o_data
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);

    twrtc_pkg::t_req r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/twrtc_back.sv]
module twrtc_back #(
    parameter int unsigned BURST_BYTES = twrtc_pkg::BurstBytesDefault
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_idx,
    input  logic [7:0]      i_cfg_data,
    input  logic            i_valid,
    output logic            o_pop,
    input  twrtc_pkg::t_req i_req,
    output logic            o_valid,
    input  logic            i_ready,
    output twrtc_pkg::t_res o_res
);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_SETUP = 2'd1;
    localparam logic [1:0] PH_LOW   = 2'd2;
    localparam logic [1:0] PH_HIGH  = 2'd3;
    localparam logic [3:0] Burst    = 4'(BURST_BYTES);

    logic [7:0]  r_half;
    logic [7:0]  r_setup;
    logic [1:0]  r_phase, n_phase;
    logic [7:0]  r_tick, n_tick;
    logic [2:0]  r_bit, n_bit;
    logic [3:0]  r_byte, n_byte;
    logic [7:0]  r_shift, n_shift;
    logic [1:0]  r_op, n_op;
    logic [55:0] r_wdata, n_wdata;
    logic [55:0] r_gath, n_gath;
    logic        r_out_valid;
    twrtc_pkg::t_res r_out;
    twrtc_pkg::t_res res;

    logic        step;
    logic [7:0]  tick_inc;
    logic        sent;
    logic        n_sent;
    logic        done;
    logic        drive;
    logic [3:0]  next_byte;
    logic [2:0]  gidx;
    logic [2:0]  widx;
    logic [7:0]  wbyte;

    assign step    = i_valid && (!r_out_valid || i_ready);
    assign o_pop   = step;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half  <= 8'd1;
            r_setup <= 8'd3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                twrtc_pkg::CFG_HALF_BIT: r_half  <= i_cfg_data;
                twrtc_pkg::CFG_SETUP:    r_setup <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next byte to send in a write
    always_comb begin
        next_byte = r_byte + 4'd1;
        widx      = 3'(next_byte - 4'd1);
        if (!r_op[0] || next_byte == 4'd0 || next_byte > Burst || next_byte > 4'd7) begin
            wbyte = 8'd0;
        end else begin
            wbyte = r_wdata[8*widx +: 8];
        end
    end

    // one tick of the serial engine
    always_comb begin
        n_phase  = r_phase;
        n_tick   = r_tick;
        n_bit    = r_bit;
        n_byte   = r_byte;
        n_shift  = r_shift;
        n_op     = r_op;
        n_wdata  = r_wdata;
        n_gath   = r_gath;
        done     = 1'b0;
        tick_inc = r_tick + 8'd1;
        sent     = (r_byte == 4'd0) || r_op[0];
        gidx     = 3'(r_byte - 4'd1);
        unique case (r_phase)
            PH_IDLE: begin
                if (i_req.start_req) begin
                    n_op    = i_req.func;
                    n_wdata = i_req.write_bytes;
                    n_gath  = '0;
                    n_shift = i_req.cmd_byte;
                    n_byte  = 4'd0;
                    n_bit   = 3'd0;
                    n_tick  = 8'd0;
                    n_phase = PH_SETUP;
                end
            end
            PH_SETUP: begin
                n_tick = tick_inc;
                if (tick_inc >= r_setup) begin
                    n_tick  = 8'd0;
                    n_phase = PH_LOW;
                end
            end
            PH_LOW: begin
                n_tick = tick_inc;
                if (tick_inc >= r_half) begin
                    if (!sent) begin
                        n_shift = {i_req.io_in, r_shift[7:1]};
                    end
                    n_tick  = 8'd0;
                    n_phase = PH_HIGH;
                end
            end
            PH_HIGH: begin
                n_tick = tick_inc;
                if (tick_inc >= r_half) begin
                    n_tick = 8'd0;
                    if (r_bit == 3'd7) begin
                        if (!sent && r_byte >= 4'd1 && r_byte <= 4'd7) begin
                            n_gath[8*gidx +: 8] = r_gath[8*gidx +: 8] | r_shift;
                        end
                        if (r_byte >= twrtc_pkg::last_byte(r_op, Burst)) begin
                            n_phase = PH_IDLE;
                            done    = 1'b1;
                            n_bit   = 3'd0;
                            n_byte  = 4'd0;
                            n_shift = 8'd0;
                        end else begin
                            n_byte  = next_byte;
                            n_bit   = 3'd0;
                            n_shift = wbyte;
                            n_phase = PH_LOW;
                        end
                    end else begin
                        n_bit = r_bit + 3'd1;
                        if (sent) begin
                            n_shift = {1'b0, r_shift[7:1]};
                        end
                        n_phase = PH_LOW;
                    end
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    // pin levels after the update
    always_comb begin
        n_sent           = (n_byte == 4'd0) || n_op[0];
        drive            = (n_phase == PH_LOW || n_phase == PH_HIGH) && n_sent;
        res.chip_enable  = (n_phase != PH_IDLE);
        res.serial_clock = (n_phase == PH_HIGH);
        res.io_out       = drive && n_shift[0];
        res.io_drive     = drive;
        res.busy_res     = (n_phase != PH_IDLE);
        res.done_res     = done;
        res.read_bytes   = done ? n_gath : 56'd0;
    end

    // engine state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= '0;
            r_bit   <= '0;
            r_byte  <= '0;
            r_shift <= '0;
            r_op    <= '0;
            r_wdata <= '0;
            r_gath  <= '0;
        end else if (step) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
            r_byte  <= n_byte;
            r_shift <= n_shift;
            r_op    <= n_op;
            r_wdata <= n_wdata;
            r_gath  <= n_gath;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (step) begin
            r_out <= res;
        end
    end

    // an idle tick without a start request stays idle
    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && r_phase == PH_IDLE && !i_req.start_req |=> r_phase == PH_IDLE)
        else $error("engine left idle without a start request");

    // byte counter never passes the final byte
    a_byte_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_IDLE |-> r_byte <= twrtc_pkg::last_byte(r_op, Burst))
        else $error("byte index beyond the final byte");

    // write transactions return no read data
    a_write_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.done_res && r_op[0] |-> r_out.read_bytes == 56'd0)
        else $error("read data after a write");

    // data pin is only driven with chip enable high
    a_drive_ce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.io_drive |-> r_out.chip_enable && !r_out.done_res)
        else $error("data pin driven outside a transaction");

endmodule
